// File: rtl/core/pesd_pkg.sv
// Shared types and constants for the per-entry state debouncer.
// No dependencies; imported by the update unit, the top level and the checker.
package pesd_pkg;

  localparam int NUM_SEATS_DEFAULT = 64;

  localparam int SEAT_W  = 6;
  localparam int TS_W    = 32;
  localparam int CONF_W  = 16;
  localparam int DWELL_W = 16;
  localparam int IN_W    = 72;   // 70 field bits padded to whole bytes
  localparam int OUT_W   = 24;
  localparam int CFG_IDX_W = 2;

  // Q0.16 value of 0.65, rounded to nearest
  localparam logic [CONF_W-1:0] CONF_AVAILABLE = 16'd42598;

  typedef enum logic [1:0] {
    ST_AVAILABLE = 2'd0,
    ST_OCCUPIED  = 2'd1,
    ST_CLAIMED   = 2'd2,
    ST_UNCERTAIN = 2'd3
  } seat_state_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DWELL_OCCUPIED  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DWELL_CLAIMED   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DWELL_AVAILABLE = 2'd2;

  localparam logic [DWELL_W-1:0] DWELL_OCCUPIED_RST  = 16'd750;
  localparam logic [DWELL_W-1:0] DWELL_CLAIMED_RST   = 16'd1200;
  localparam logic [DWELL_W-1:0] DWELL_AVAILABLE_RST = 16'd2500;

  typedef struct packed {
    logic [DWELL_W-1:0] occupied;
    logic [DWELL_W-1:0] claimed;
    logic [DWELL_W-1:0] available;
  } dwell_cfg_t;

  // one table entry
  typedef struct packed {
    seat_state_t       settled;
    logic [TS_W-1:0]   since;
    seat_state_t       cand;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{settled: ST_UNCERTAIN, since: '0, cand: ST_UNCERTAIN};

  // update unit result
  typedef struct packed {
    seat_state_t       stable;
    logic [CONF_W-1:0] conf;
    entry_t            next;
  } upd_result_t;

endpackage

// File: rtl/core/pesd_update.sv
// Classify one observation and compute the next table entry.
// Depends on pesd_pkg.
module pesd_update import pesd_pkg::*; (
  input  entry_t            cur,
  input  logic [TS_W-1:0]   now,
  input  logic [CONF_W-1:0] person,
  input  logic [CONF_W-1:0] item,
  input  dwell_cfg_t        dwell,
  output upd_result_t       res
);

  seat_state_t        obs;
  logic [CONF_W-1:0]  conf;
  logic [DWELL_W-1:0] dwell_sel;
  logic [TS_W-1:0]    since_new;
  logic [TS_W-1:0]    elapsed;
  seat_state_t        settled_new;

  always_comb begin
    if (person != '0) begin
      obs  = ST_OCCUPIED;
      conf = person;
    end else if (item != '0) begin
      obs  = ST_CLAIMED;
      conf = item;
    end else begin
      obs  = ST_AVAILABLE;
      conf = CONF_AVAILABLE;
    end

    unique case (obs)
      ST_OCCUPIED: dwell_sel = dwell.occupied;
      ST_CLAIMED:  dwell_sel = dwell.claimed;
      default:     dwell_sel = dwell.available;
    endcase

    // new candidate restarts its timer
    since_new = (cur.cand != obs) ? now : cur.since;
    elapsed   = now - since_new;   // wraps mod 2^32
    settled_new = (elapsed >= {{(TS_W-DWELL_W){1'b0}}, dwell_sel}) ? obs : cur.settled;

    res.next.cand    = obs;
    res.next.since   = since_new;
    res.next.settled = settled_new;
    res.stable       = settled_new;
    res.conf         = conf;
  end

endmodule

// File: rtl/core/per_entry_state_debouncer.sv
// Top level of the per-entry state debouncer: stream ports, seat table memory,
// output register. Depends on pesd_pkg and pesd_update.
//
//  channel   | signals                        | width | role
//  ----------+--------------------------------+-------+---------------------------
//  s_*       | s_tvalid s_tready s_tdata      | 72    | observation words in
//  m_*       | m_tvalid m_tready m_tdata      | 24    | debounced result words out
//  cfg_*     | cfg_valid cfg_ready cfg_index  | 2     | dwell register writes
//            | cfg_data                       | 16    |
//
// Per word: the accepting edge takes the word and reads its seat entry from the
// table RAM into a read register; the finishing edge, taken once the output
// register is free, writes the updated entry back and loads the output
// register. One observation is in flight at a time, so a read never overlaps
// a pending write. The output register lets the next word be accepted while a
// result waits on m_tready; a stalled output holds the update until freed.
// Reset: synchronous, active high. Per-entry valid flops clear at once, so no
// clearing pass; an entry never written reads as uncertain, time zero.
module per_entry_state_debouncer import pesd_pkg::*; #(
  parameter int NUM_SEATS = NUM_SEATS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  // lsb up: seat_index[5:0], timestamp_ms[37:6], person_confidence[53:38],
  //         item_confidence[69:54], zero pad[71:70]
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IN_W-1:0]      s_tdata,
  // lsb up: result_seat[5:0], stable_state[7:6], confidence[23:8]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [OUT_W-1:0]     m_tdata,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DWELL_W-1:0]   cfg_data
);

  // only seats the 6-bit index can reach get table rows
  localparam int DEPTH = (NUM_SEATS < (1 << SEAT_W)) ? NUM_SEATS : (1 << SEAT_W);
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // dwell registers
  dwell_cfg_t dwell;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dwell.occupied  <= DWELL_OCCUPIED_RST;
      dwell.claimed   <= DWELL_CLAIMED_RST;
      dwell.available <= DWELL_AVAILABLE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DWELL_OCCUPIED:  dwell.occupied  <= cfg_data;
        REG_DWELL_CLAIMED:   dwell.claimed   <= cfg_data;
        REG_DWELL_AVAILABLE: dwell.available <= cfg_data;
        default: ;   // unmapped index, ignored
      endcase
    end
  end

  // input capture
  logic                 busy;
  logic [SEAT_W-1:0]    seat;
  logic [TS_W-1:0]      now;
  logic [CONF_W-1:0]    person;
  logic [CONF_W-1:0]    item;
  logic                 in_accept;
  logic [AW-1:0]        s_addr;
  logic [AW-1:0]        addr;
  logic                 in_range;

  assign s_tready  = !busy;
  assign in_accept = s_tvalid && s_tready;
  assign s_addr    = s_tdata[AW-1:0];
  assign addr      = seat[AW-1:0];
  assign in_range  = (32'(seat) < 32'(NUM_SEATS));

  // seat table RAM plus per-row valid flops
  entry_t           mem [DEPTH];
  entry_t           rdata;
  logic [DEPTH-1:0] row_valid;
  entry_t           cur;
  upd_result_t      res;
  logic             out_free;
  logic             finish;

  assign out_free = !m_tvalid || m_tready;
  assign finish   = busy && out_free;
  assign cur      = row_valid[addr] ? rdata : ENTRY_RESET;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      rdata <= mem[s_addr];
    end
    if (finish && in_range) begin
      mem[addr] <= res.next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (finish && in_range) begin
      row_valid[addr] <= 1'b1;
    end
  end

  pesd_update u_update (
    .cur    (cur),
    .now    (now),
    .person (person),
    .item   (item),
    .dwell  (dwell),
    .res    (res)
  );

  // control and payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      seat   <= s_tdata[SEAT_W-1:0];
      now    <= s_tdata[SEAT_W+TS_W-1:SEAT_W];
      person <= s_tdata[SEAT_W+TS_W+CONF_W-1:SEAT_W+TS_W];
      item   <= s_tdata[SEAT_W+TS_W+2*CONF_W-1:SEAT_W+TS_W+CONF_W];
    end
    if (finish) begin
      m_tdata <= {res.conf, (in_range ? res.stable : ST_UNCERTAIN), seat};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (in_accept) begin
        busy <= 1'b1;
      end else if (finish) begin
        busy <= 1'b0;
      end
      if (finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/core/pesd_checker.sv
// Port-level checks for the per-entry state debouncer, bound to the top level.
// Depends on pesd_pkg and per_entry_state_debouncer.
module pesd_checker import pesd_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic [IN_W-1:0]      s_tdata,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [OUT_W-1:0]     m_tdata
);

  logic s_acc;
  assign s_acc = s_tvalid && s_tready;

  // a stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed under stall");

  // one word in flight: no accept right after an accept
  a_one: assert property (@(posedge clk) disable iff (rst)
    s_acc |=> !s_tready)
    else $error("input accepted while previous word in flight");

  // a result with the accepted seat follows when the output is free
  a_seat: assert property (@(posedge clk) disable iff (rst)
    $past(s_acc) && !$past(rst) && (!m_tvalid || m_tready)
      |=> m_tvalid && (m_tdata[5:0] == $past(s_tdata[5:0], 2)))
    else $error("result seat mismatch or missing");

  // confidence follows the classification of the accepted word
  a_conf: assert property (@(posedge clk) disable iff (rst)
    $past(s_acc) && !$past(rst) && (!m_tvalid || m_tready)
      |=> m_tdata[23:8] == (($past(s_tdata[53:38], 2) != '0) ? $past(s_tdata[53:38], 2) :
                            ($past(s_tdata[69:54], 2) != '0) ? $past(s_tdata[69:54], 2) :
                            CONF_AVAILABLE))
    else $error("result confidence mismatch");

  // reset empties the output
  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind per_entry_state_debouncer pesd_checker u_pesd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
